// File: sv/source_text_tokenizer_macros.svh
// Assertion macros for the source text tokenizer.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/stt_pkg.sv
// Shared types, constants and keyword helpers for the source text tokenizer.
// Used by every tokenizer module; depends on nothing.
package stt_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int POS_WIDTH     = 32;
   localparam int LEN_WIDTH     = $clog2(MAX_TOKEN_LEN + 1);
   localparam int KW_COUNT      = 7;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [2:0] KW_NONE = 3'd7;
   localparam logic [7:0] CHAR_EQ = "=";

   // Byte classes produced by the front end.
   typedef enum logic [3:0] {
      CLS_SPACE  = 4'd0,
      CLS_DIGIT  = 4'd1,
      CLS_ALPHA  = 4'd2,
      CLS_UNDER  = 4'd3,
      CLS_EQ     = 4'd4,
      CLS_CMP    = 4'd5,
      CLS_ARITH  = 4'd6,
      CLS_SYMBOL = 4'd7,
      CLS_OTHER  = 4'd8
   } stt_class_type;

   // Token record kinds.
   typedef enum logic [2:0] {
      KIND_NUMBER   = 3'd0,
      KIND_IDENT    = 3'd1,
      KIND_KEYWORD  = 3'd2,
      KIND_OPERATOR = 3'd3,
      KIND_SYMBOL   = 3'd4,
      KIND_END      = 3'd5,
      KIND_UNKNOWN  = 3'd6
   } stt_kind_type;

   // Lexer modes.
   typedef enum logic [3:0] {
      MODE_IDLE  = 4'b0001,
      MODE_NUM   = 4'b0010,
      MODE_IDENT = 4'b0100,
      MODE_OP    = 4'b1000
   } stt_mode_type;

   // One classified input item as it waits in the queue.
   typedef struct packed {
      logic          is_end;
      stt_class_type cls;
      logic [7:0]    ch;
   } stt_entry_type;

   // One token record.
   typedef struct packed {
      stt_kind_type kind;
      logic [2:0]   kw;
      logic [7:0]   op_first;
      logic [7:0]   op_second;
      logic [31:0]  start_pos;
      logic [7:0]   len;
   } stt_record_type;

   // Keyword spellings, padded with zero bytes.
   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"d", "e", "c", "l", "a", "r", "e", 8'h00},
      '{"p", "r", "i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd4, 3'd7, 3'd5, 3'd6, 3'd3, 3'd4
   };

   // Drop every keyword that does not have byte c at offset pos.
   function automatic logic [KW_COUNT-1:0] narrow_candidates(
      input logic [KW_COUNT-1:0]  cand,
      input logic [7:0]           c,
      input logic [LEN_WIDTH-1:0] pos
   );
      logic [KW_COUNT-1:0] result;
      result = cand;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (pos >= LEN_WIDTH'(KW_LEN[k]) || KW_TEXT[k][pos[2:0]] != c) begin
            result[k] = 1'b0;
         end
      end
      return result;
   endfunction

   // Lowest-numbered keyword still matching whose length equals the run.
   function automatic logic [2:0] match_keyword(
      input logic [KW_COUNT-1:0]  cand,
      input logic [LEN_WIDTH-1:0] len
   );
      logic [2:0] kw;
      kw = KW_NONE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cand[k] && len == LEN_WIDTH'(KW_LEN[k])) begin
            kw = 3'(k);
         end
      end
      return kw;
   endfunction

endpackage

// File: sv/stt_front.sv
// Front end of the tokenizer: accepts source bytes and classifies them.
// Depends on stt_pkg; feeds stt_queue.
module stt_front (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             char_in,
   input  logic                   is_end,
   output logic                   push_valid,
   input  logic                   push_ready,
   output stt_pkg::stt_entry_type push_entry
);

   stt_pkg::stt_class_type cls;

   // Character classification of the incoming byte.
   always_comb begin
      if (char_in == " " || (char_in >= 8'd9 && char_in <= 8'd13)) begin
         cls = stt_pkg::CLS_SPACE;
      end else if (char_in >= "0" && char_in <= "9") begin
         cls = stt_pkg::CLS_DIGIT;
      end else if ((char_in >= "a" && char_in <= "z") ||
                   (char_in >= "A" && char_in <= "Z")) begin
         cls = stt_pkg::CLS_ALPHA;
      end else if (char_in == "_") begin
         cls = stt_pkg::CLS_UNDER;
      end else if (char_in == stt_pkg::CHAR_EQ) begin
         cls = stt_pkg::CLS_EQ;
      end else if (char_in == "!" || char_in == "<" || char_in == ">") begin
         cls = stt_pkg::CLS_CMP;
      end else if (char_in == "+" || char_in == "-" || char_in == "*" ||
                   char_in == "/") begin
         cls = stt_pkg::CLS_ARITH;
      end else if (char_in == ";" || char_in == ":" || char_in == "{" ||
                   char_in == "}" || char_in == "(" || char_in == ")" ||
                   char_in == ",") begin
         cls = stt_pkg::CLS_SYMBOL;
      end else begin
         cls = stt_pkg::CLS_OTHER;
      end
   end

   // A transaction is taken whenever the queue has room.
   assign req_tready        = push_ready;
   assign push_valid        = req_tvalid;
   assign push_entry.is_end = is_end;
   assign push_entry.cls    = cls;
   assign push_entry.ch     = char_in;

endmodule

// File: sv/stt_queue.sv
// Short register queue between the tokenizer front end and the lexer.
// Depends on stt_pkg for the entry type and depth.
module stt_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  stt_pkg::stt_entry_type push_entry,
   output logic                   pop_valid,
   input  logic                   pop,
   output stt_pkg::stt_entry_type pop_entry
);

   localparam int PW = stt_pkg::QUEUE_PTR_W;

   stt_pkg::stt_entry_type store_ff [stt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != (PW + 1)'(stt_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = store_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(stt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(stt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/stt_back.sv
// Lexer back end: runs the token state machine on queued items and drives
// the output register. Depends on stt_pkg.
module stt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  stt_pkg::stt_entry_type  head,
   output logic                    head_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output stt_pkg::stt_record_type rsp_record,
   output logic                    rsp_last
);

   localparam int LW = stt_pkg::LEN_WIDTH;
   localparam int PW = stt_pkg::POS_WIDTH;
   localparam int KC = stt_pkg::KW_COUNT;

   stt_pkg::stt_mode_type   mode_ff, mode_in;
   logic [7:0]              pending_ff, pending_in;
   logic [LW-1:0]           run_ff, run_in;
   logic [KC-1:0]           cand_ff, cand_in;
   logic [PW-1:0]           start_ff, start_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic                    phase_ff, phase_in;
   logic                    out_valid_ff, out_valid_in;
   stt_pkg::stt_record_type out_rec_ff;
   logic                    out_last_ff;

   stt_pkg::stt_record_type flush_rec, byte_rec, join_rec, end_rec, rec0, rec1;
   logic                    has_flush, out_free, commit, load, load_last;
   logic [1:0]              n_rec;
   logic [2:0]              flush_kw;
   logic [LW-1:0]           run_inc;
   logic                    cont_num, cont_id, join_eq;

   assign has_flush = mode_ff != stt_pkg::MODE_IDLE;
   assign flush_kw  = stt_pkg::match_keyword(cand_ff, run_ff);
   assign run_inc   = (run_ff < LW'(stt_pkg::MAX_TOKEN_LEN)) ? run_ff + 1'b1 : run_ff;

   // Record of the token being built.
   always_comb begin
      flush_rec.kw        = stt_pkg::KW_NONE;
      flush_rec.op_first  = 8'd0;
      flush_rec.op_second = 8'd0;
      flush_rec.start_pos = 32'(start_ff);
      flush_rec.len       = 8'(run_ff);
      unique case (mode_ff)
         stt_pkg::MODE_NUM: begin
            flush_rec.kind = stt_pkg::KIND_NUMBER;
         end
         stt_pkg::MODE_IDENT: begin
            flush_rec.kw   = flush_kw;
            flush_rec.kind = (flush_kw == stt_pkg::KW_NONE) ? stt_pkg::KIND_IDENT
                                                            : stt_pkg::KIND_KEYWORD;
         end
         stt_pkg::MODE_OP: begin
            flush_rec.kind     = stt_pkg::KIND_OPERATOR;
            flush_rec.op_first = pending_ff;
            flush_rec.len      = 8'd1;
         end
         default: begin
            flush_rec.kind = stt_pkg::KIND_END;
         end
      endcase
   end

   // Single-byte records, the joined operator and the end record.
   always_comb begin
      byte_rec.kw        = stt_pkg::KW_NONE;
      byte_rec.op_first  = head.ch;
      byte_rec.op_second = 8'd0;
      byte_rec.start_pos = 32'(pos_ff);
      byte_rec.len       = 8'd1;
      case (head.cls)
         stt_pkg::CLS_ARITH:  byte_rec.kind = stt_pkg::KIND_OPERATOR;
         stt_pkg::CLS_SYMBOL: byte_rec.kind = stt_pkg::KIND_SYMBOL;
         default:             byte_rec.kind = stt_pkg::KIND_UNKNOWN;
      endcase

      join_rec.kind      = stt_pkg::KIND_OPERATOR;
      join_rec.kw        = stt_pkg::KW_NONE;
      join_rec.op_first  = pending_ff;
      join_rec.op_second = stt_pkg::CHAR_EQ;
      join_rec.start_pos = 32'(start_ff);
      join_rec.len       = 8'd2;

      end_rec.kind       = stt_pkg::KIND_END;
      end_rec.kw         = stt_pkg::KW_NONE;
      end_rec.op_first   = 8'd0;
      end_rec.op_second  = 8'd0;
      end_rec.start_pos  = 32'(pos_ff);
      end_rec.len        = 8'd0;
   end

   assign cont_num = mode_ff == stt_pkg::MODE_NUM && head.cls == stt_pkg::CLS_DIGIT;
   assign cont_id  = mode_ff == stt_pkg::MODE_IDENT &&
                     (head.cls == stt_pkg::CLS_DIGIT || head.cls == stt_pkg::CLS_ALPHA ||
                      head.cls == stt_pkg::CLS_UNDER);
   assign join_eq  = mode_ff == stt_pkg::MODE_OP && head.cls == stt_pkg::CLS_EQ;

   // Next lexer state and the records caused by the head item.
   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      run_in     = run_ff;
      cand_in    = cand_ff;
      start_in   = start_ff;
      pos_in     = pos_ff + 1'b1;
      n_rec      = 2'd0;
      rec0       = byte_rec;
      rec1       = byte_rec;
      if (head.is_end) begin
         // Flush, then the end record; everything returns to reset.
         mode_in    = stt_pkg::MODE_IDLE;
         pending_in = 8'd0;
         run_in     = '0;
         cand_in    = '1;
         start_in   = '0;
         pos_in     = '0;
         n_rec      = has_flush ? 2'd2 : 2'd1;
         rec0       = has_flush ? flush_rec : end_rec;
         rec1       = end_rec;
      end else if (cont_num || cont_id) begin
         run_in  = run_inc;
         cand_in = cont_id ? stt_pkg::narrow_candidates(cand_ff, head.ch, run_ff) : cand_ff;
      end else if (join_eq) begin
         mode_in    = stt_pkg::MODE_IDLE;
         pending_in = 8'd0;
         n_rec      = 2'd1;
         rec0       = join_rec;
      end else begin
         // Close the pending token, then treat the byte as a new start.
         mode_in    = stt_pkg::MODE_IDLE;
         pending_in = 8'd0;
         n_rec      = {1'b0, has_flush};
         rec0       = has_flush ? flush_rec : byte_rec;
         case (head.cls) inside
            stt_pkg::CLS_SPACE: begin
            end
            stt_pkg::CLS_DIGIT, stt_pkg::CLS_ALPHA: begin
               mode_in  = (head.cls == stt_pkg::CLS_DIGIT) ? stt_pkg::MODE_NUM
                                                           : stt_pkg::MODE_IDENT;
               start_in = pos_ff;
               run_in   = LW'(1);
               cand_in  = (head.cls == stt_pkg::CLS_ALPHA) ?
                          stt_pkg::narrow_candidates('1, head.ch, '0) : '1;
            end
            stt_pkg::CLS_EQ, stt_pkg::CLS_CMP: begin
               mode_in    = stt_pkg::MODE_OP;
               pending_in = head.ch;
               start_in   = pos_ff;
            end
            default: begin
               n_rec = n_rec + 2'd1;
            end
         endcase
      end
   end

   // Sequencing: two-record items use a second pass with the state held.
   assign out_free = !out_valid_ff || rsp_tready;
   always_comb begin
      commit    = 1'b0;
      load      = 1'b0;
      load_last = 1'b1;
      phase_in  = phase_ff;
      if (head_valid) begin
         if (phase_ff) begin
            if (out_free) begin
               load     = 1'b1;
               commit   = 1'b1;
               phase_in = 1'b0;
            end
         end else if (n_rec == 2'd0) begin
            commit = 1'b1;
         end else if (out_free) begin
            load = 1'b1;
            if (n_rec == 2'd1) begin
               commit = 1'b1;
            end else begin
               load_last = 1'b0;
               phase_in  = 1'b1;
            end
         end
      end
      out_valid_in = load || (out_valid_ff && !rsp_tready);
   end

   assign head_pop = commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= stt_pkg::MODE_IDLE;
         pending_ff   <= 8'd0;
         run_ff       <= '0;
         cand_ff      <= '1;
         start_ff     <= '0;
         pos_ff       <= '0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            mode_ff    <= mode_in;
            pending_ff <= pending_in;
            run_ff     <= run_in;
            cand_ff    <= cand_in;
            start_ff   <= start_in;
            pos_ff     <= pos_in;
         end
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (load) begin
         out_rec_ff  <= phase_ff ? rec1 : rec0;
         out_last_ff <= load_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_record = out_rec_ff;
   assign rsp_last   = out_last_ff;

endmodule

// File: sv/source_text_tokenizer.sv
// Source text tokenizer: one source byte per cycle in while the queue has
// room, one token record out. An accepted byte is stored in the queue, then
// its first record is loaded into the output register. A byte that closes
// one token and emits another, or an end marker after a pending token, holds
// the lexer for a second pass, which the four-entry queue absorbs.
// Synchronous reset clears the queue, lexer state, offset and output valid.
`include "source_text_tokenizer_macros.svh"

module source_text_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tuser,   // [0] is_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [2:0] token_kind, [5:3] keyword_index,
                                    // [13:6] op_first, [21:14] op_second,
                                    // [53:22] start_pos, [61:54] token_len
   output logic        rsp_tlast    // last
);

   logic                    push_valid, push_ready, pop_valid, head_pop;
   stt_pkg::stt_entry_type  push_entry, head;
   stt_pkg::stt_record_type rsp_record;

   // Classifier front end.
   stt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_in    (req_tdata),
      .is_end     (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   stt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (head_pop),
      .pop_entry  (head)
   );

   // Lexer back end.
   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (pop_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_record (rsp_record),
      .rsp_last   (rsp_tlast)
   );

   // Pack the record into the result bus.
   assign rsp_tdata = {2'b00, rsp_record.len, rsp_record.start_pos,
                       rsp_record.op_second, rsp_record.op_first,
                       rsp_record.kw, rsp_record.kind};

   // The lexer only consumes an item that the queue holds.
   `STT_ASSERT_NOW(a_pop_has_item, head_pop, pop_valid, "lexer popped an empty queue")

   // An end record always closes the transaction's records.
   `STT_ASSERT_NOW(a_end_is_last, rsp_tvalid && rsp_tdata[2:0] == stt_pkg::KIND_END,
      rsp_tlast, "end record without last")

   // A keyword index appears exactly on keyword records.
   `STT_ASSERT_NOW(a_kw_index, rsp_tvalid,
      (rsp_tdata[2:0] == stt_pkg::KIND_KEYWORD) == (rsp_tdata[5:3] != stt_pkg::KW_NONE),
      "keyword index does not match record kind")

   // A record without last is followed by the second record of the same item.
   `STT_ASSERT_NEXT(a_pair_follows, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid, "second record of a pair missing")

endmodule
